### rtl/core/itp_pkg.sv
// package: word types, character codes and register indexes of the ipv4 text parser
package itp_pkg;

  // character codes
  localparam logic [7:0] CHAR_ZERO = 8'h30;
  localparam logic [7:0] CHAR_NINE = 8'h39;
  localparam logic [7:0] CHAR_DOT  = 8'h2e;

  // octet limits and address width
  localparam int unsigned ADDR_W      = 32;
  localparam int unsigned OCTET_W     = 9;
  localparam logic [8:0]  OCTET_LIMIT = 9'd255;
  localparam logic [8:0]  OCTET_SAT   = 9'd256;
  localparam logic [1:0]  SEG_FULL    = 2'd3;

  // configuration register indexes
  localparam int unsigned CFG_IDX_W = 2;
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_NETWORK_ADDRESS = 2'd0,
    CFG_PREFIX_LENGTH   = 2'd1
  } cfg_idx_t;

  localparam logic [5:0] PREFIX_RESET = 6'd32;
  localparam logic [5:0] PREFIX_MAX   = 6'd32;

  // input word: one character of address text
  typedef struct packed {
    logic [7:0] character;
    logic       last;
  } in_word_t;

  // result word
  typedef struct packed {
    logic [ADDR_W-1:0] address;
    logic              valid_res;
    logic              in_range;
  } out_word_t;

endpackage

### rtl/core/ipv4_text_parse_prefix_match_core.sv
// top level: dotted-decimal ipv4 parser with network prefix match
//
//  channel | direction | handshake          | word
//  in_     | input     | in_valid/in_stall  | in_word_t  (character, last)
//  out_    | output    | out_valid/out_stall| out_word_t (address, valid_res, in_range)
//  cfg_    | input     | cfg_valid/cfg_ready| cfg_index, cfg_data
//
// one character per cycle while in_stall is low; the parse accumulators update
// in the accept cycle and a word with last set loads the result register, seen
// in the next cycle. rst_n (synchronous) clears the accumulators, the result
// valid and the registers to network 0, prefix 32. input stalls only while a
// result is held and out_stall is high; cfg_ready is always high.
module ipv4_text_parse_prefix_match_core
  import itp_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  in_word_t             in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output out_word_t            out_data,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [ADDR_W-1:0]    cfg_data
);

  // configuration registers
  logic [ADDR_W-1:0] network_r;
  logic [5:0]        prefix_r;

  // parse state
  logic [OCTET_W-1:0] octet_r, octet_nxt;
  logic [1:0]         seg_r, seg_nxt;
  logic               digit_r, digit_nxt;
  logic               err_r, err_nxt;
  logic [23:0]        packed_r, packed_nxt;

  // result register
  logic      out_valid_r;
  out_word_t out_data_r, out_data_nxt;

  logic        in_accept;
  logic [3:0]  digit_val;
  logic [11:0] octet_prod;
  logic        addr_ok;
  logic [ADDR_W-1:0] addr_full;
  logic [5:0]        prefix_eff;
  logic [ADDR_W-1:0] prefix_mask;

  assign cfg_ready = 1'b1;
  assign in_stall  = out_valid_r & out_stall;
  assign in_accept = in_valid & ~in_stall;

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      network_r <= '0;
      prefix_r  <= PREFIX_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_NETWORK_ADDRESS: network_r <= cfg_data;
        CFG_PREFIX_LENGTH:   prefix_r  <= cfg_data[5:0];
        default: ;
      endcase
    end
  end

  // character classification and accumulator update
  always_comb begin
    digit_val  = 4'(in_data.character - CHAR_ZERO);
    octet_prod = {octet_r, 3'b000} + {2'b00, octet_r, 1'b0} + {8'h00, digit_val};
    octet_nxt  = octet_r;
    seg_nxt    = seg_r;
    digit_nxt  = digit_r;
    err_nxt    = err_r;
    packed_nxt = packed_r;
    case (in_data.character) inside
      [CHAR_ZERO:CHAR_NINE]: begin
        octet_nxt = (octet_prod > 12'(OCTET_SAT)) ? OCTET_SAT : octet_prod[OCTET_W-1:0];
        digit_nxt = 1'b1;
      end
      CHAR_DOT: begin
        if (!digit_r || octet_r > OCTET_LIMIT || seg_r == SEG_FULL) begin
          err_nxt = 1'b1;
        end else begin
          packed_nxt = {packed_r[15:0], octet_r[7:0]};
          seg_nxt    = seg_r + 2'd1;
        end
        octet_nxt = '0;
        digit_nxt = 1'b0;
      end
      default: begin
        err_nxt = 1'b1;
      end
    endcase
  end

  // final check and prefix compare on the last character
  always_comb begin
    addr_ok     = ~err_nxt & (seg_nxt == SEG_FULL) & digit_nxt & (octet_nxt <= OCTET_LIMIT);
    addr_full   = {packed_nxt, octet_nxt[7:0]};
    prefix_eff  = (prefix_r > PREFIX_MAX) ? PREFIX_MAX : prefix_r;
    prefix_mask = (prefix_eff == 6'd0) ? '0 : ({ADDR_W{1'b1}} << (PREFIX_MAX - prefix_eff));
    out_data_nxt.address   = addr_ok ? addr_full : '0;
    out_data_nxt.valid_res = addr_ok;
    out_data_nxt.in_range  = addr_ok & ((addr_full & prefix_mask) == (network_r & prefix_mask));
  end

  // parse state registers, cleared after each address
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      octet_r  <= '0;
      seg_r    <= '0;
      digit_r  <= 1'b0;
      err_r    <= 1'b0;
      packed_r <= '0;
    end else if (in_accept) begin
      if (in_data.last) begin
        octet_r  <= '0;
        seg_r    <= '0;
        digit_r  <= 1'b0;
        err_r    <= 1'b0;
        packed_r <= '0;
      end else begin
        octet_r  <= octet_nxt;
        seg_r    <= seg_nxt;
        digit_r  <= digit_nxt;
        err_r    <= err_nxt;
        packed_r <= packed_nxt;
      end
    end
  end

  // result valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_accept && in_data.last) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (in_accept && in_data.last) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

### rtl/core/itp_checker.sv
// checker: port-level assertions on the ipv4 text parser, with its bind
module itp_checker
  import itp_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      in_valid,
  input logic      in_stall,
  input in_word_t  in_data,
  input logic      out_valid,
  input logic      out_stall,
  input out_word_t out_data
);

  // a held result keeps its word
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // a match only on a valid address
  a_range_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.in_range |-> out_data.valid_res)
    else $error("in_range set on invalid address");

  // invalid address reads as zero
  a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.valid_res |-> out_data.address == '0)
    else $error("invalid address not zero");

  // last character gives a result the next cycle
  a_last_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && in_data.last |=> out_valid)
    else $error("no result after last character");

endmodule

bind ipv4_text_parse_prefix_match_core itp_checker u_itp_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
